FILE: rtl/lswe_pkg.sv
// ----------------------------------------------------------------------------
// lswe_pkg
// Shared types and constants for the link supervisor: link states, sequencer
// states, register map, reset values and the controller/datapath structs.
// ----------------------------------------------------------------------------
package lswe_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned PctMax   = 100;
  localparam int unsigned NumW     = 15;  // magnitude of (rssi - floor) * 100
  localparam int unsigned DivCntW  = 4;

  localparam logic [31:0] ConnectTimeoutRst = 32'd15000;
  localparam logic [31:0] RetryIntervalRst  = 32'd30000;
  localparam logic [31:0] ResetAfterRst     = 32'd3600000;
  localparam logic [31:0] RebootAfterRst    = 32'd14400000;
  localparam logic [7:0]  RssiFloorRst      = 8'h9C;  // -100 dBm
  localparam logic [7:0]  RssiTopRst        = 8'hD8;  // -40 dBm

  typedef enum logic [1:0] {
    LS_IDLE         = 2'd0,
    LS_CONNECTING   = 2'd1,
    LS_CONNECTED    = 2'd2,
    LS_DISCONNECTED = 2'd3
  } link_state_e;

  typedef enum logic [1:0] {
    CS_WAIT = 2'd0,
    CS_EVAL = 2'd1,
    CS_ESC  = 2'd2,
    CS_DIV  = 2'd3
  } ctrl_state_e;

  typedef enum logic [2:0] {
    REG_CONNECT_TIMEOUT = 3'd0,
    REG_RETRY_INTERVAL  = 3'd1,
    REG_RESET_AFTER     = 3'd2,
    REG_REBOOT_AFTER    = 3'd3,
    REG_RSSI_FLOOR      = 3'd4,
    REG_RSSI_TOP        = 3'd5
  } cfg_idx_e;

  localparam logic [0:0] CmdBegin = 1'b0;

  typedef struct packed {
    logic [31:0] connect_timeout;
    logic [31:0] retry_interval;
    logic [31:0] reset_after;
    logic [31:0] reboot_after;
    logic [7:0]  rssi_floor;
    logic [7:0]  rssi_top;
  } lswe_cfg_t;

  typedef struct packed {
    logic        take;
    logic        set_state;
    link_state_e next_state;
    logic        mark_attempt;
    logic        mark_connected;
    logic        escalate_reset;
    logic        reboot;
    logic        out_load;
  } lswe_cmd_t;

  typedef struct packed {
    logic        cmd_update;
    logic        link_up;
    link_state_e link_state;
    logic        timeout_hit;
    logic        retry_hit;
    logic        reset_hit;
    logic        reboot_hit;
    logic        reset_done;
    logic        div_done;
    logic        out_free;
  } lswe_sts_t;

endpackage

FILE: rtl/lswe_if.sv
// ----------------------------------------------------------------------------
// lswe_if
// Valid/ready channels of the link supervisor: command beats in, status
// beats out.
// ----------------------------------------------------------------------------
interface lswe_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [31:0]       now_ms;
  logic              link_up;
  logic signed [7:0] rssi_dbm;

  modport source (output valid, command, now_ms, link_up, rssi_dbm, input ready);
  modport sink (input valid, command, now_ms, link_up, rssi_dbm, output ready);
endinterface

interface lswe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_state;
  logic [6:0] signal_percent;
  logic       attempt_request;
  logic       adapter_reset_request;
  logic       reboot_request;

  modport source (output valid, link_state, signal_percent, attempt_request,
                  adapter_reset_request, reboot_request, input ready);
  modport sink (input valid, link_state, signal_percent, attempt_request,
                adapter_reset_request, reboot_request, output ready);
endinterface

FILE: rtl/lswe_cfg.sv
// ----------------------------------------------------------------------------
// lswe_cfg
// APB register file holding timeouts, escalation thresholds and the rssi
// calibration points.
// ----------------------------------------------------------------------------
module lswe_cfg import lswe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lswe_cfg_t           cfg_o
);

  lswe_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  cfg_idx_e  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = cfg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CONNECT_TIMEOUT: cfg_d.connect_timeout = pwdata;
        REG_RETRY_INTERVAL:  cfg_d.retry_interval  = pwdata;
        REG_RESET_AFTER:     cfg_d.reset_after     = pwdata;
        REG_REBOOT_AFTER:    cfg_d.reboot_after    = pwdata;
        REG_RSSI_FLOOR:      cfg_d.rssi_floor      = pwdata[7:0];
        REG_RSSI_TOP:        cfg_d.rssi_top        = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connect_timeout <= ConnectTimeoutRst;
      cfg_q.retry_interval  <= RetryIntervalRst;
      cfg_q.reset_after     <= ResetAfterRst;
      cfg_q.reboot_after    <= RebootAfterRst;
      cfg_q.rssi_floor      <= RssiFloorRst;
      cfg_q.rssi_top        <= RssiTopRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // signed dbm registers read back sign extended
  always_comb begin
    case (idx)
      REG_CONNECT_TIMEOUT: prdata = cfg_q.connect_timeout;
      REG_RETRY_INTERVAL:  prdata = cfg_q.retry_interval;
      REG_RESET_AFTER:     prdata = cfg_q.reset_after;
      REG_REBOOT_AFTER:    prdata = cfg_q.reboot_after;
      REG_RSSI_FLOOR:      prdata = {{24{cfg_q.rssi_floor[7]}}, cfg_q.rssi_floor};
      REG_RSSI_TOP:        prdata = {{24{cfg_q.rssi_top[7]}}, cfg_q.rssi_top};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/lswe_dp.sv
// ----------------------------------------------------------------------------
// lswe_dp
// Datapath: captured beat, link state and timestamps, elapsed-time compares,
// bit-serial percentage divider and the output register.
// ----------------------------------------------------------------------------
module lswe_dp import lswe_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lswe_cfg_t         cfg_i,
  input  lswe_cmd_t         cmd_i,
  output lswe_sts_t         sts_o,
  input  logic              command_i,
  input  logic [31:0]       now_ms_i,
  input  logic              link_up_i,
  input  logic signed [7:0] rssi_dbm_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        link_state_o,
  output logic [6:0]        signal_percent_o,
  output logic              attempt_request_o,
  output logic              adapter_reset_request_o,
  output logic              reboot_request_o
);

  localparam int unsigned CmpW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int unsigned DivSteps = NumW;

  // captured beat
  logic                  cmd_q;
  logic                  up_q;
  logic [TIME_WIDTH-1:0] now_q;

  // supervisor state
  link_state_e           link_q, link_d;
  logic [TIME_WIDTH-1:0] entered_q, entered_d;
  logic [TIME_WIDTH-1:0] last_att_q, last_att_d;
  logic [TIME_WIDTH-1:0] last_conn_q, last_conn_d;
  logic                  reset_done_q, reset_done_d;

  // per-beat request flags
  logic attempt_q, attempt_d;
  logic adapter_q, adapter_d;
  logic reboot_q, reboot_d;

  // elapsed times, wrapping
  logic [TIME_WIDTH-1:0] el_state, el_att, el_down;

  // divider
  logic signed [8:0]   span_s, diff_s;
  logic signed [15:0]  num_s;
  logic [15:0]         num_mag;
  logic [8:0]          span_mag;
  logic                div_zero;
  logic [NumW-1:0]     quo_q, quo_d;
  logic [7:0]          rem_q, rem_d;
  logic [7:0]          div_q;
  logic                zero_q;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [8:0]          trial;
  logic [6:0]          pct;

  // output register
  logic       out_valid_q;
  logic [1:0] o_state_q;
  logic [6:0] o_pct_q;
  logic       o_att_q, o_adp_q, o_rbt_q;

  assign el_state = now_q - entered_q;
  assign el_att   = now_q - last_att_q;
  assign el_down  = now_q - last_conn_q;

  always_comb begin
    sts_o.cmd_update  = cmd_q;
    sts_o.link_up     = up_q;
    sts_o.link_state  = link_q;
    sts_o.timeout_hit = CmpW'(el_state) >= CmpW'(cfg_i.connect_timeout);
    sts_o.retry_hit   = CmpW'(el_att) >= CmpW'(cfg_i.retry_interval);
    sts_o.reset_hit   = CmpW'(el_down) >= CmpW'(cfg_i.reset_after);
    sts_o.reboot_hit  = CmpW'(el_down) >= CmpW'(cfg_i.reboot_after);
    sts_o.reset_done  = reset_done_q;
    sts_o.div_done    = (cnt_q == '0);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // supervisor state updates
  always_comb begin
    link_d       = link_q;
    entered_d    = entered_q;
    last_att_d   = last_att_q;
    last_conn_d  = last_conn_q;
    reset_done_d = reset_done_q;
    attempt_d    = attempt_q;
    adapter_d    = adapter_q;
    reboot_d     = reboot_q;
    if (cmd_i.take) begin
      attempt_d = 1'b0;
      adapter_d = 1'b0;
      reboot_d  = 1'b0;
    end
    if (cmd_i.mark_attempt) begin
      last_att_d = now_q;
      attempt_d  = 1'b1;
    end
    // a transition to the current state keeps the entry time
    if (cmd_i.set_state && (cmd_i.next_state != link_q)) begin
      link_d    = cmd_i.next_state;
      entered_d = now_q;
    end
    if (cmd_i.mark_connected) begin
      last_conn_d  = now_q;
      reset_done_d = 1'b0;
    end
    if (cmd_i.escalate_reset) begin
      adapter_d    = 1'b1;
      reset_done_d = 1'b1;
    end
    if (cmd_i.reboot) begin
      link_d       = LS_IDLE;
      entered_d    = '0;
      last_att_d   = '0;
      last_conn_d  = '0;
      reset_done_d = 1'b0;
      attempt_d    = 1'b0;
      reboot_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q       <= LS_IDLE;
      entered_q    <= '0;
      last_att_q   <= '0;
      last_conn_q  <= '0;
      reset_done_q <= 1'b0;
    end else begin
      link_q       <= link_d;
      entered_q    <= entered_d;
      last_att_q   <= last_att_d;
      last_conn_q  <= last_conn_d;
      reset_done_q <= reset_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    attempt_q <= attempt_d;
    adapter_q <= adapter_d;
    reboot_q  <= reboot_d;
    if (cmd_i.take) begin
      cmd_q <= command_i;
      up_q  <= link_up_i;
      now_q <= TIME_WIDTH'(now_ms_i);
    end
  end

  // divider operands: (rssi - floor) * 100 over (top - floor), magnitudes only
  always_comb begin
    span_s   = $signed({cfg_i.rssi_top[7], cfg_i.rssi_top})
             - $signed({cfg_i.rssi_floor[7], cfg_i.rssi_floor});
    diff_s   = $signed({rssi_dbm_i[7], rssi_dbm_i})
             - $signed({cfg_i.rssi_floor[7], cfg_i.rssi_floor});
    num_s    = $signed({{7{diff_s[8]}}, diff_s}) * 16'sd100;
    num_mag  = num_s[15] ? 16'(-num_s) : 16'(num_s);
    span_mag = span_s[8] ? 9'(-span_s) : 9'(span_s);
    // negative or zero quotient clamps to zero anyway
    div_zero = (span_s == 9'sd0) || (num_s == 16'sd0) || (num_s[15] != span_s[8]);
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[NumW-1]};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.take) begin
      quo_d = num_mag[NumW-1:0];
      rem_d = '0;
      cnt_d = DivCntW'(DivSteps);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = 8'(trial - {1'b0, div_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.take) begin
      div_q  <= span_mag[7:0];
      zero_q <= div_zero;
    end
  end

  assign pct = zero_q ? 7'd0
             : (quo_q > NumW'(PctMax)) ? 7'(PctMax) : quo_q[6:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_state_q <= link_q;
      o_pct_q   <= (link_q == LS_CONNECTED) ? pct : 7'd0;
      o_att_q   <= attempt_q;
      o_adp_q   <= adapter_q;
      o_rbt_q   <= reboot_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign link_state_o            = o_state_q;
  assign signal_percent_o        = o_pct_q;
  assign attempt_request_o       = o_att_q;
  assign adapter_reset_request_o = o_adp_q;
  assign reboot_request_o        = o_rbt_q;

`ifndef SYNTH
  a_reboot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_rbt_q |-> (o_state_q == LS_IDLE) && !o_att_q && !o_adp_q)
    else $error("reboot beat not idle or carries requests");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_pct_q <= 7'(PctMax))
                    && ((o_pct_q == 7'd0) || (o_state_q == LS_CONNECTED)))
    else $error("signal percent out of range or not connected");

  a_adapter_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_adp_q |-> o_att_q && (o_state_q == LS_CONNECTING))
    else $error("adapter reset without a fresh attempt");
`endif

endmodule

FILE: rtl/lswe_ctrl.sv
// ----------------------------------------------------------------------------
// lswe_ctrl
// Sequencer: takes a beat, applies the link transition, runs the outage
// escalation check and hands the result to the output register.
// ----------------------------------------------------------------------------
module lswe_ctrl import lswe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lswe_sts_t sts_i,
  output lswe_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_WAIT: begin
        if (in_valid_i) state_d = CS_EVAL;
      end
      CS_EVAL: begin
        // a begin never checks for escalation
        state_d = sts_i.cmd_update ? CS_ESC : CS_DIV;
      end
      CS_ESC: begin
        state_d = CS_DIV;
      end
      CS_DIV: begin
        if (sts_i.div_done && sts_i.out_free) state_d = CS_WAIT;
      end
      default: state_d = CS_WAIT;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.next_state = LS_IDLE;
    in_ready_o       = 1'b0;
    case (state_q)
      CS_WAIT: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      CS_EVAL: begin
        if (!sts_i.cmd_update) begin
          cmd_o.set_state    = 1'b1;
          cmd_o.next_state   = LS_CONNECTING;
          cmd_o.mark_attempt = 1'b1;
        end else begin
          case (sts_i.link_state)
            LS_CONNECTING: begin
              if (sts_i.link_up) begin
                cmd_o.set_state  = 1'b1;
                cmd_o.next_state = LS_CONNECTED;
              end else if (sts_i.timeout_hit) begin
                cmd_o.set_state  = 1'b1;
                cmd_o.next_state = LS_DISCONNECTED;
              end
            end
            LS_CONNECTED: begin
              if (!sts_i.link_up) begin
                cmd_o.set_state  = 1'b1;
                cmd_o.next_state = LS_DISCONNECTED;
              end
            end
            LS_DISCONNECTED: begin
              if (sts_i.retry_hit) begin
                cmd_o.set_state    = 1'b1;
                cmd_o.next_state   = LS_CONNECTING;
                cmd_o.mark_attempt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      CS_ESC: begin
        if (sts_i.link_state == LS_CONNECTED) begin
          cmd_o.mark_connected = 1'b1;
        end else if (sts_i.reboot_hit) begin
          cmd_o.reboot = 1'b1;
        end else if (sts_i.reset_hit && !sts_i.reset_done) begin
          cmd_o.set_state      = 1'b1;
          cmd_o.next_state     = LS_CONNECTING;
          cmd_o.mark_attempt   = 1'b1;
          cmd_o.escalate_reset = 1'b1;
        end
      end
      CS_DIV: begin
        cmd_o.out_load = sts_i.div_done && sts_i.out_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_esc_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_ESC) |-> $past(state_q == CS_EVAL) && sts_i.cmd_update)
    else $error("escalation step without an update beat");
`endif

endmodule

FILE: rtl/link_supervisor_with_escalation.sv
// ----------------------------------------------------------------------------
// link_supervisor_with_escalation
// Radio link supervisor: connect attempts, timeouts, retries, outage
// escalation to adapter reset and reboot, and a clamped signal percentage.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    command, now_ms, link_up, rssi_dbm
//   out_o    out  valid/ready    link_state, signal_percent, requests
//   apb      in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// a beat is taken, then the one-bit-per-cycle percentage divider runs, then
// the result is loaded into the output register; no new beat is taken before
// that load. the link transition and escalation check run alongside the
// divider. the next beat is taken while the previous result still waits in the
// output register; the sequencer only holds when that register is still full.
// asynchronous active-low reset returns state to idle with zeroed timestamps.
// ----------------------------------------------------------------------------
module link_supervisor_with_escalation import lswe_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lswe_in_if.sink             in_i,
  lswe_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lswe_cfg_t cfg;
  lswe_cmd_t cmd;
  lswe_sts_t sts;
  logic      in_ready;

  lswe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lswe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lswe_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_i                   (cfg),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .command_i               (in_i.command),
    .now_ms_i                (in_i.now_ms),
    .link_up_i               (in_i.link_up),
    .rssi_dbm_i              (in_i.rssi_dbm),
    .out_ready_i             (out_o.ready),
    .out_valid_o             (out_o.valid),
    .link_state_o            (out_o.link_state),
    .signal_percent_o        (out_o.signal_percent),
    .attempt_request_o       (out_o.attempt_request),
    .adapter_reset_request_o (out_o.adapter_reset_request),
    .reboot_request_o        (out_o.reboot_request)
  );

  assign in_i.ready = in_ready;

endmodule
